/* rtl/core/double_ended_arena_allocator_assert.svh */
// Assertion macros shared by the arena allocator modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DOUBLE_ENDED_ARENA_ALLOCATOR_ASSERT_SVH
`define DOUBLE_ENDED_ARENA_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define DEAA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arena allocator assertion failed");

// Next-cycle implication, switched off while reset is held.
`define DEAA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arena allocator assertion failed");

`endif

/* rtl/core/deaa_pkg.sv */
// Shared types and constants for the double-ended arena allocator.
// No dependencies; used by the controller, the datapath and the top level.
package deaa_pkg;

  // Block layout: every block carries a header and is rounded to the alignment.
  // The alignment must be a power of two.
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ALIGN_BYTES  = 16;
  localparam int unsigned ALIGN_MASK   = ALIGN_BYTES - 1;

  // Field widths.
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned USED_W  = 31;
  localparam int unsigned TOTAL_W = 33;
  localparam int unsigned GAP_W   = 34;

  // Configuration register indexes.
  localparam logic CFG_ARENA_BASE = 1'b0;
  localparam logic CFG_ARENA_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ACT_ALLOC_LOW  = 3'd0,
    ACT_ALLOC_HIGH = 3'd1,
    ACT_ALLOC_TEMP = 3'd2,
    ACT_FREE_LOW   = 3'd3,
    ACT_FREE_HIGH  = 3'd4,
    ACT_READ_LOW   = 3'd5,
    ACT_READ_HIGH  = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_SIZE = 2'd1,
    STS_NO_SPACE = 2'd2,
    STS_BAD_MARK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EVAL,
    ST_COMMIT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic prep;
    logic eval;
    logic commit;
  } ctl_cmd_t;

endpackage

/* rtl/core/deaa_ctrl.sv */
// Sequencing controller for the arena allocator: load, prepare, evaluate, commit.
// Depends on deaa_pkg and the assertion macro header.
`include "double_ended_arena_allocator_assert.svh"

module deaa_ctrl
  import deaa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_commit;

  // The result register is free when empty or being taken this cycle.
  assign can_commit = !(out_valid_r && out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = ST_COMMIT;
      ST_COMMIT: if (can_commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_PREP:   cmd.prep   = 1'b1;
      ST_EVAL:   cmd.eval   = 1'b1;
      ST_COMMIT: cmd.commit = can_commit;
      default:   cmd        = '0;
    endcase
  end

  // Result valid flag: set on commit, cleared once the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A commit never overwrites a result that is still waiting.
  `DEAA_ASSERT_IMP(a_no_overwrite, cmd.commit, !(out_valid_r && out_stall))
  // An accepted item always moves on to the prepare step.
  `DEAA_ASSERT_NXT(a_accept_to_prep, in_valid && !in_stall, state_r == ST_PREP)
  // A commit always leaves a valid result behind.
  `DEAA_ASSERT_NXT(a_commit_valid, cmd.commit, out_valid_r)

endmodule

/* rtl/core/deaa_dp.sv */
// Datapath of the arena allocator: configuration, used counts, temp block and result.
// Depends on deaa_pkg and the assertion macro header; driven by deaa_ctrl.
`include "double_ended_arena_allocator_assert.svh"

module deaa_dp
  import deaa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_request_size,
  input  logic signed [31:0]  in_target_mark,
  output logic [1:0]          out_status,
  output logic [ADDR_W-1:0]   out_user_address,
  output logic [USED_W-1:0]   out_mark_value
);

  // Configuration and allocator state.
  logic [ADDR_W-1:0] arena_base_r;
  logic [USED_W-1:0] arena_size_r;
  logic [USED_W-1:0] low_used_r, low_used_nxt;
  logic [USED_W-1:0] high_used_r, high_used_nxt;
  logic              temp_active_r, temp_active_nxt;
  logic [USED_W-1:0] temp_mark_r, temp_mark_nxt;

  // Captured item.
  action_t            act_r;
  logic signed [31:0] size_r;
  logic signed [31:0] mark_r;

  // Prepare step.
  logic [31:0]        rnd;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               rel_r, rel_nxt;
  logic [USED_W-1:0]  base_high_r, base_high_nxt;
  logic [GAP_W-1:0]   gap_plain_r, gap_plain_nxt;
  logic [GAP_W-1:0]   gap_temp_r, gap_temp_nxt;
  logic [ADDR_W-1:0]  low_addr_r, low_addr_nxt;
  logic [ADDR_W-1:0]  top_r, top_nxt;

  // Evaluate step.
  logic [GAP_W-1:0]   gap_sel;
  logic               fits;
  logic               mark_low_ok, mark_high_ok;
  status_t            status_r, status_nxt;
  logic [USED_W-1:0]  nh_r, nh_nxt;
  logic [USED_W-1:0]  nl_r, nl_nxt;

  // Result register.
  status_t            res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [USED_W-1:0]  res_mark_r, res_mark_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_base_r <= '0;
      arena_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ARENA_BASE: arena_base_r <= cfg_data;
        CFG_ARENA_SIZE: arena_size_r <= cfg_data[USED_W-1:0];
        default:        arena_base_r <= arena_base_r;
      endcase
    end
  end

  // Capture the item on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= action_t'(in_action);
      size_r <= in_request_size;
      mark_r <= in_target_mark;
    end
  end

  // Prepare: block total, temp release view, free gaps and base addresses.
  always_comb begin
    rnd = ({1'b0, size_r[30:0]} + 32'(ALIGN_MASK)) & ~32'(ALIGN_MASK);
    total_nxt     = {1'b0, rnd} + TOTAL_W'(HEADER_BYTES);
    rel_nxt       = temp_active_r && (temp_mark_r <= high_used_r);
    base_high_nxt = rel_nxt ? temp_mark_r : high_used_r;
    gap_plain_nxt = {3'b0, arena_size_r} - {3'b0, low_used_r} - {3'b0, high_used_r};
    gap_temp_nxt  = {3'b0, arena_size_r} - {3'b0, low_used_r} - {3'b0, temp_mark_r};
    low_addr_nxt  = arena_base_r + {1'b0, low_used_r} + ADDR_W'(HEADER_BYTES);
    top_nxt       = arena_base_r + {1'b0, arena_size_r} + ADDR_W'(HEADER_BYTES);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      total_r     <= total_nxt;
      rel_r       <= rel_nxt;
      base_high_r <= base_high_nxt;
      gap_plain_r <= gap_plain_nxt;
      gap_temp_r  <= gap_temp_nxt;
      low_addr_r  <= low_addr_nxt;
      top_r       <= top_nxt;
    end
  end

  // Evaluate: fit and mark checks, new used counts and the status.
  always_comb begin
    if ((act_r == ACT_ALLOC_HIGH || act_r == ACT_ALLOC_TEMP) && rel_r) begin
      gap_sel = gap_temp_r;
    end else begin
      gap_sel = gap_plain_r;
    end
    fits         = !gap_sel[GAP_W-1] && (gap_sel[TOTAL_W-1:0] >= total_r);
    mark_low_ok  = !mark_r[31] && (mark_r[30:0] <= low_used_r);
    mark_high_ok = !mark_r[31] && (mark_r[30:0] <= base_high_r);
    nh_nxt       = base_high_r + total_r[USED_W-1:0];
    nl_nxt       = low_used_r + total_r[USED_W-1:0];
    unique case (act_r)
      ACT_ALLOC_LOW, ACT_ALLOC_HIGH, ACT_ALLOC_TEMP: begin
        if (size_r[31]) begin
          status_nxt = STS_BAD_SIZE;
        end else if (!fits) begin
          status_nxt = STS_NO_SPACE;
        end else begin
          status_nxt = STS_OK;
        end
      end
      ACT_FREE_LOW:  status_nxt = mark_low_ok  ? STS_OK : STS_BAD_MARK;
      ACT_FREE_HIGH: status_nxt = mark_high_ok ? STS_OK : STS_BAD_MARK;
      default:       status_nxt = STS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status_r <= status_nxt;
      nh_r     <= nh_nxt;
      nl_r     <= nl_nxt;
    end
  end

  // Commit: state update and result item.
  always_comb begin
    low_used_nxt    = low_used_r;
    high_used_nxt   = high_used_r;
    temp_active_nxt = temp_active_r;
    temp_mark_nxt   = temp_mark_r;
    res_status_nxt  = status_r;
    res_addr_nxt    = '0;
    res_mark_nxt    = '0;
    unique case (act_r)
      ACT_ALLOC_LOW: begin
        if (status_r == STS_OK) begin
          low_used_nxt = nl_r;
          res_addr_nxt = low_addr_r;
        end
        res_mark_nxt = low_used_nxt;
      end
      ACT_ALLOC_HIGH, ACT_ALLOC_TEMP: begin
        if (status_r == STS_OK) begin
          high_used_nxt   = nh_r;
          temp_active_nxt = (act_r == ACT_ALLOC_TEMP);
          if (act_r == ACT_ALLOC_TEMP) begin
            temp_mark_nxt = base_high_r;
          end
          res_addr_nxt = top_r - {1'b0, nh_r};
        end
        res_mark_nxt = high_used_nxt;
      end
      ACT_FREE_LOW: begin
        if (status_r == STS_OK) begin
          low_used_nxt = mark_r[USED_W-1:0];
        end
        res_mark_nxt = low_used_nxt;
      end
      ACT_FREE_HIGH: begin
        if (status_r == STS_OK) begin
          high_used_nxt   = mark_r[USED_W-1:0];
          temp_active_nxt = 1'b0;
        end
        res_mark_nxt = high_used_nxt;
      end
      ACT_READ_LOW: res_mark_nxt = low_used_r;
      ACT_READ_HIGH: begin
        high_used_nxt   = base_high_r;
        temp_active_nxt = 1'b0;
        res_mark_nxt    = base_high_r;
      end
      ACT_CLEAR: begin
        low_used_nxt    = '0;
        high_used_nxt   = '0;
        temp_active_nxt = 1'b0;
        temp_mark_nxt   = '0;
      end
      default: res_mark_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_used_r    <= '0;
      high_used_r   <= '0;
      temp_active_r <= 1'b0;
      temp_mark_r   <= '0;
    end else if (cmd.commit) begin
      low_used_r    <= low_used_nxt;
      high_used_r   <= high_used_nxt;
      temp_active_r <= temp_active_nxt;
      temp_mark_r   <= temp_mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= res_status_nxt;
      res_addr_r   <= res_addr_nxt;
      res_mark_r   <= res_mark_nxt;
    end
  end

  assign out_status       = res_status_r;
  assign out_user_address = res_addr_r;
  assign out_mark_value   = res_mark_r;

  // An active temp block always sits above its own release mark.
  `DEAA_ASSERT_IMP(a_temp_below_high, temp_active_r, temp_mark_r <= high_used_r)
  // A failed item leaves the used counts untouched.
  `DEAA_ASSERT_IMP(a_error_keeps_state,
                   cmd.commit && status_r != STS_OK,
                   low_used_nxt == low_used_r && high_used_nxt == high_used_r)

endmodule

/* rtl/core/double_ended_arena_allocator.sv */
// Double-ended arena allocator: low blocks grow up from arena_base, high blocks grow
// down from arena_base + arena_size, and each request costs its size rounded up to
// 16 bytes plus a 16-byte header. One item is handled at a time: it is accepted,
// then goes through prepare, evaluate and commit steps of the controller, and the
// next item can be accepted in the cycle after commit. The commit waits while an
// earlier result is still held in the output register. Every item gives exactly
// one result with a status, an address for successful allocations and the
// used-byte mark of the side it touched. Configuration writes are always ready
// and must only be issued while no item is in flight.
// Depends on deaa_pkg, deaa_ctrl and deaa_dp.

module double_ended_arena_allocator
  import deaa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Item input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_request_size,
  input  logic signed [31:0] in_target_mark,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_user_address,
  output logic [30:0]        out_mark_value,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  ctl_cmd_t cmd;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencing.
  deaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic, state and result register.
  deaa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_target_mark   (in_target_mark),
    .out_status       (out_status),
    .out_user_address (out_user_address),
    .out_mark_value   (out_mark_value)
  );

endmodule

/* sim/double_ended_arena_allocator_checker.sv */
// Checker for the double-ended arena allocator: watches the item, result and register channels,
// predicts every result from its own copy of the arena state and compares it field by field.
// Depends on deaa_pkg for the action and status codes, the register indexes and the block layout.

module double_ended_arena_allocator_checker
  import deaa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_request_size,
  input  logic signed [31:0] in_target_mark,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic [31:0]        out_user_address,
  input  logic [30:0]        out_mark_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatch_count,
  output int                 waiting_count
);

  typedef struct packed {
    status_t     status;
    logic [31:0] user_address;
    logic [30:0] mark_value;
  } arena_reply_t;

  // Replies predicted for accepted items, oldest first.
  arena_reply_t reply_q[$];

  // Shadow copy of the registers and of the two stacks.
  logic [31:0] base_r;
  logic [30:0] size_r;
  logic [30:0] low_used_r;
  logic [30:0] high_used_r;
  logic [30:0] temp_mark_r;
  logic        temp_live_r;
  int          errors = 0;

  initial begin
    mismatch_count = 0;
    waiting_count  = 0;
  end

  // Bytes a request takes: payload rounded up to the alignment, plus the header.
  function automatic longint block_cost(longint req);
    return longint'(HEADER_BYTES) +
           ((req + longint'(ALIGN_BYTES) - 1) / longint'(ALIGN_BYTES)) * longint'(ALIGN_BYTES);
  endfunction

  // The free gap may be negative once the arena has been shrunk under the used bytes.
  function automatic bit gap_covers(longint high_side, longint cost);
    longint gap;
    gap = longint'(size_r) - longint'(low_used_r) - high_side;
    return (gap >= 0) && (gap >= cost);
  endfunction

  // High used bytes once any temporary block has been given back.
  function automatic logic [30:0] high_released();
    return (temp_live_r && temp_mark_r <= high_used_r) ? temp_mark_r : high_used_r;
  endfunction

  // Applies one item to the shadow state and works out its reply.
  task automatic apply_request(input action_t act, input logic signed [31:0] req,
                               input logic signed [31:0] mark, output arena_reply_t r);
    longint      cost;
    longint      req_l;
    longint      mark_l;
    logic [30:0] start_high;
    logic [30:0] new_high;
    req_l  = longint'(req);
    mark_l = longint'(mark);
    r      = '0;
    case (act)
      ACT_ALLOC_LOW: begin
        if (req_l < 0) begin
          r.status = STS_BAD_SIZE;
        end else begin
          cost = block_cost(req_l);
          if (!gap_covers(longint'(high_used_r), cost)) begin
            r.status = STS_NO_SPACE;
          end else begin
            r.user_address = base_r + 32'(low_used_r) + 32'(HEADER_BYTES);
            low_used_r     = 31'(longint'(low_used_r) + cost);
          end
        end
        r.mark_value = low_used_r;
      end
      ACT_ALLOC_HIGH, ACT_ALLOC_TEMP: begin
        if (req_l < 0) begin
          r.status = STS_BAD_SIZE;
        end else begin
          start_high = high_released();
          cost       = block_cost(req_l);
          if (!gap_covers(longint'(start_high), cost)) begin
            r.status = STS_NO_SPACE;
          end else begin
            new_high    = 31'(longint'(start_high) + cost);
            high_used_r = new_high;
            temp_live_r = (act == ACT_ALLOC_TEMP);
            if (act == ACT_ALLOC_TEMP) begin
              temp_mark_r = start_high;
            end
            r.user_address = base_r + 32'(size_r) - 32'(new_high) + 32'(HEADER_BYTES);
          end
        end
        r.mark_value = high_used_r;
      end
      ACT_FREE_LOW: begin
        if (mark_l < 0 || mark_l > longint'(low_used_r)) begin
          r.status = STS_BAD_MARK;
        end else begin
          low_used_r = 31'(mark_l);
        end
        r.mark_value = low_used_r;
      end
      ACT_FREE_HIGH: begin
        start_high = high_released();
        if (mark_l < 0 || mark_l > longint'(start_high)) begin
          r.status = STS_BAD_MARK;
        end else begin
          high_used_r = 31'(mark_l);
          temp_live_r = 1'b0;
        end
        r.mark_value = high_used_r;
      end
      ACT_READ_LOW: begin
        r.mark_value = low_used_r;
      end
      ACT_READ_HIGH: begin
        high_used_r  = high_released();
        temp_live_r  = 1'b0;
        r.mark_value = high_used_r;
      end
      default: begin
        low_used_r  = '0;
        high_used_r = '0;
        temp_live_r = 1'b0;
        temp_mark_r = '0;
      end
    endcase
  endtask

  // Reports one field that differs from its prediction.
  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Results are compared before the item of the same edge is predicted; the two are never
  // the same item because an accepted item still has to pass the prepare, evaluate and commit steps.
  always @(posedge clk) begin
    arena_reply_t want;
    if (!rst_n) begin
      reply_q.delete();
      base_r      = '0;
      size_r      = '0;
      low_used_r  = '0;
      high_used_r = '0;
      temp_mark_r = '0;
      temp_live_r = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with none expected, got status %0d address 0x%0h mark %0d",
                   $time, out_status, out_user_address, out_mark_value);
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("user_address", want.user_address, out_user_address);
          check_field("mark_value", want.mark_value, out_mark_value);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ARENA_BASE) begin
          base_r = cfg_data;
        end else begin
          size_r = cfg_data[30:0];
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(action_t'(in_action), in_request_size, in_target_mark, want);
        reply_q.push_back(want);
      end
    end
    mismatch_count <= errors;
    waiting_count  <= reply_q.size();
  end

endmodule

/* sim/tb_double_ended_arena_allocator.sv */
// Top of the arena allocator testbench: clock, reset, register writes and item stimulus,
// with random idling on both channels and the final verdict.
// Depends on deaa_pkg, double_ended_arena_allocator and double_ended_arena_allocator_checker.

module tb_double_ended_arena_allocator;
  import deaa_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 150;
  localparam int IDLE_PERCENT  = 33;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [2:0]         in_action        = ACT_READ_LOW;
  logic signed [31:0] in_request_size  = '0;
  logic signed [31:0] in_target_mark   = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [1:0]         out_status;
  logic [31:0]        out_user_address;
  logic [30:0]        out_mark_value;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic               cfg_index        = CFG_ARENA_BASE;
  logic [31:0]        cfg_data         = '0;

  int          mismatch_count;
  int          waiting_count;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int          cfg_writes  = 0;
  bit          calm        = 1'b0;
  logic [30:0] seen_mark   = '0;

  double_ended_arena_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_target_mark   (in_target_mark),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_user_address (out_user_address),
    .out_mark_value   (out_mark_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  double_ended_arena_allocator_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_request_size  (in_request_size),
    .in_target_mark   (in_target_mark),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_user_address (out_user_address),
    .out_mark_value   (out_mark_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .waiting_count    (waiting_count)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, waiting_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The result side stalls at random, except during the calm phase.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // The most recent mark seen on the result channel gives the stimulus marks that often hold.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      seen_mark <= out_mark_value;
    end
  end

  // Presents one item after a random gap and waits until the block takes it.
  task automatic send_item(input action_t act, input logic signed [31:0] req,
                           input logic signed [31:0] mark);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_request_size <= req;
    in_target_mark  <= mark;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops the item stream and waits until every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic configure(input logic [31:0] base, input logic [31:0] size);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ARENA_BASE;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ARENA_SIZE;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  // One random item: mostly small sizes and plausible marks, with some wild values.
  task automatic random_item();
    action_t            act;
    logic signed [31:0] req;
    logic signed [31:0] mark;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      act = ACT_ALLOC_LOW;
    else if (pick < 38) act = ACT_ALLOC_HIGH;
    else if (pick < 54) act = ACT_ALLOC_TEMP;
    else if (pick < 67) act = ACT_FREE_LOW;
    else if (pick < 80) act = ACT_FREE_HIGH;
    else if (pick < 88) act = ACT_READ_LOW;
    else if (pick < 95) act = ACT_READ_HIGH;
    else                act = ACT_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 70)      req = $urandom_range(0, 160);
    else if (pick < 80) req = 32'h8000_0000 | $urandom();
    else if (pick < 90) req = $urandom();
    else begin
      case ($urandom_range(0, 5))
        0:       req = 0;
        1:       req = 1;
        2:       req = 15;
        3:       req = 17;
        4:       req = 32'h7FFF_FFF0;
        default: req = 32'h7FFF_FFFF;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 45)      mark = {1'b0, seen_mark};
    else if (pick < 55) mark = {1'b0, seen_mark} + 32'd16;
    else if (pick < 75) mark = 16 * $urandom_range(0, 64);
    else if (pick < 85) mark = 32'h8000_0000 | $urandom();
    else                mark = $urandom();
    send_item(act, req, mark);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // With the registers at reset the arena is empty, so even a zero-byte request fails.
    send_item(ACT_ALLOC_LOW, 0, 0);
    send_item(ACT_READ_LOW, 0, 0);
    send_item(ACT_READ_HIGH, 0, 0);
    settle();

    // Directed walk through every action in a 512-byte arena.
    configure(32'h0000_1000, 32'd512);
    send_item(ACT_ALLOC_LOW, 0, 0);
    send_item(ACT_ALLOC_LOW, 1, 0);
    send_item(ACT_ALLOC_LOW, 16, 0);
    send_item(ACT_ALLOC_LOW, -1, 0);
    send_item(ACT_ALLOC_LOW, 32'h7FFF_FFFF, 0);
    send_item(ACT_ALLOC_HIGH, 17, 0);
    send_item(ACT_ALLOC_TEMP, 32, 0);
    send_item(ACT_READ_HIGH, 0, 0);
    send_item(ACT_ALLOC_TEMP, 0, 0);
    send_item(ACT_ALLOC_HIGH, 0, 0);
    send_item(ACT_ALLOC_TEMP, 64, 0);
    // Failing temp requests must leave the live temporary block in place.
    send_item(ACT_ALLOC_TEMP, -5, 0);
    send_item(ACT_ALLOC_TEMP, 1000, 0);
    send_item(ACT_FREE_HIGH, 0, 32'h7FFF_FFFF);
    send_item(ACT_FREE_HIGH, 0, -1);
    send_item(ACT_FREE_HIGH, 0, 64);
    send_item(ACT_FREE_LOW, 0, 16);
    send_item(ACT_FREE_LOW, 0, 1000);
    send_item(ACT_FREE_LOW, 0, 32'h8000_0000);
    send_item(ACT_READ_LOW, 0, 0);
    send_item(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // An exact fit fills the arena; nothing more fits after it.
    send_item(ACT_ALLOC_LOW, 496, 0);
    send_item(ACT_ALLOC_HIGH, 0, 0);
    send_item(ACT_CLEAR, 0, 0);
    settle();

    // Largest arena at the top of the address space, so user addresses wrap.
    configure(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC_LOW, 32'h7FFF_FFE0, 0);
    send_item(ACT_ALLOC_HIGH, 0, 0);
    send_item(ACT_FREE_LOW, 0, 32'h7FFF_FFF0);
    send_item(ACT_FREE_LOW, 0, 0);
    send_item(ACT_ALLOC_TEMP, 32'h7FFF_FFD0, 0);
    send_item(ACT_READ_HIGH, 0, 0);

    // Random phases; registers change without a clear, so used bytes may exceed the size.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0:       configure(32'h0000_0000, 32'd1024);
        1:       configure(32'hFFFF_FFFF, {$urandom_range(0, 1) == 1, 31'd96});
        2:       configure($urandom(), {1'b0, 31'($urandom_range(256, 8192))});
        3:       configure(32'h8000_0000, 32'h8000_0000);
        4:       configure($urandom(), {1'b1, 31'd600});
        default: configure(32'hFFFF_FFF0, 32'h7FFF_FFFF);
      endcase
      calm <= (p == 2);
      repeat (PHASE_ITEMS) random_item();
    end
    settle();

    $display("Sent %0d items across %0d register writes: all actions, size and mark extremes,",
             items_sent, cfg_writes);
    $display("arena shrink under used bytes, address wrap, with random and stall-free stretches.");
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
